@@ rtl/srtf_scheduler_defines.svh @@
// ---------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Shared assertion forms for the scheduler checker.
// ---------------------------------------------------------------------------
`ifndef SRTF_SCHEDULER_DEFINES_SVH
`define SRTF_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SRTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srtf_scheduler: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SRTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtf_scheduler: next-cycle check failed");

`endif

@@ rtl/srtf_pkg.sv @@
// ---------------------------------------------------------------------------
// SRTF scheduler package
// Field widths, limits and the structs passed along the cell chain.
// ---------------------------------------------------------------------------
package srtf_pkg;

  localparam int TIME_W  = 20;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 5;
  localparam int SLOT_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX  = 20'hFFFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 5'd31;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Best candidate seen so far, handed from cell to cell.
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] rt;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
  } cand_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic wr;
    logic dec;
    logic en;
  } cell_ctrl_t;

endpackage

@@ rtl/srtf_cell.sv @@
// ---------------------------------------------------------------------------
// SRTF scheduler cell
// One process slot plus one stage of the running minimum search.
// ---------------------------------------------------------------------------
module srtf_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  srtf_pkg::cell_ctrl_t         ctrl,
  input  logic [srtf_pkg::VAL_W-1:0]   wr_arrival,
  input  logic [srtf_pkg::VAL_W-1:0]   wr_burst,
  input  logic [srtf_pkg::TIME_W-1:0]  current_time,
  input  srtf_pkg::cand_t              cand_in,
  input  logic [IDX_W-1:0]             idx_in,
  output srtf_pkg::cand_t              cand_out,
  output logic [IDX_W-1:0]             idx_out
);

  logic [srtf_pkg::VAL_W-1:0] arrival;
  logic [srtf_pkg::VAL_W-1:0] burst;
  logic [srtf_pkg::VAL_W-1:0] remaining;
  logic                       elig;
  logic                       take;

  assign elig = ctrl.en
              && ({{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, arrival} <= current_time)
              && (remaining != '0);
  assign take = elig && (!cand_in.found || (remaining < cand_in.rt));

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      arrival   <= wr_arrival;
      burst     <= wr_burst;
      remaining <= wr_burst;
    end else if (ctrl.dec) begin
      remaining <= remaining - 1'b1;
    end
  end

  // The candidate register only moves the search forward; it never needs reset.
  always_ff @(posedge clk) begin
    if (take) begin
      cand_out <= '{found: 1'b1, rt: remaining, arrival: arrival, burst: burst};
      idx_out  <= IDX_W'(INDEX);
    end else begin
      cand_out <= cand_in;
      idx_out  <= idx_in;
    end
  end

endmodule

@@ rtl/srtf_scheduler.sv @@
// ---------------------------------------------------------------------------
// SRTF scheduler
// Preemptive shortest-remaining-time-first scheduler over a row of slot cells.
// ---------------------------------------------------------------------------
// Usage: write process_count on cfg_write/cfg_data while the block is idle.
// Input transfers carry an action: a load writes one slot's arrival and burst
// times, a tick serves one time unit to the eligible slot with the least
// remaining time, ties going to the lowest slot. Every input transfer yields
// exactly one output transfer.
// A load's result goes through the finish state into the output register once
// the load is accepted. For a tick, the best candidate walks down the chain of
// slot cells, one cell per cycle, then the update state applies it and the
// finish state places the result in the output register. Only then is the
// next item taken, so a new load or tick waits until the last one is through.
// A tick after every counted slot has finished is answered like a load.
// in_stall is high while an item is at work. A new item is accepted while an
// earlier result still waits; a finished result waits in place until the
// receiver lowers out_stall. Reset clears the time counter, the completion
// count, process_count and the output valid; slots are undefined until loaded.
// ---------------------------------------------------------------------------
module srtf_scheduler #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [srtf_pkg::CNT_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic [srtf_pkg::SLOT_W-1:0]        slot,
  input  logic [srtf_pkg::VAL_W-1:0]         arrival_time,
  input  logic [srtf_pkg::VAL_W-1:0]         burst_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [srtf_pkg::SLOT_W-1:0]        ran_slot,
  output logic                               cpu_idle,
  output logic                               finished,
  output logic [srtf_pkg::TIME_W-1:0]        completion_time,
  output logic [srtf_pkg::TIME_W-1:0]        turnaround,
  output logic [srtf_pkg::TIME_W-1:0]        waiting,
  output logic                               all_done
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  // Wide enough for both the 5-bit register and the table depth.
  localparam int AW = ($clog2(MAX_PROCESSES + 1) > srtf_pkg::CNT_W) ?
                      $clog2(MAX_PROCESSES + 1) : srtf_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_FINISH} state_t;

  state_t                        state;
  logic [IDX_W-1:0]              scan_cnt;
  logic [srtf_pkg::CNT_W-1:0]    process_count;
  logic [srtf_pkg::TIME_W-1:0]   current_time;
  logic [srtf_pkg::CNT_W-1:0]    completed_count;

  // Result held between the update and the output register.
  logic [srtf_pkg::SLOT_W-1:0]   p_ran;
  logic                          p_idle;
  logic                          p_fin;
  logic [srtf_pkg::TIME_W-1:0]   p_ct;
  logic [srtf_pkg::TIME_W-1:0]   p_tat;
  logic [srtf_pkg::VAL_W-1:0]    p_burst;
  logic                          p_done;

  logic [AW-1:0]                 active;
  logic                          done_now;
  logic                          accept;
  logic                          out_free;
  logic [IDX_W+srtf_pkg::SLOT_W-1:0] slot_x;
  logic [IDX_W+srtf_pkg::SLOT_W-1:0] win_x;

  srtf_pkg::cand_t               cand [MAX_PROCESSES+1];
  logic [IDX_W-1:0]              idx  [MAX_PROCESSES+1];
  srtf_pkg::cell_ctrl_t          ctrl [MAX_PROCESSES];

  srtf_pkg::cand_t               last;
  logic [IDX_W-1:0]              last_idx;
  logic                          fin_hit;
  logic [srtf_pkg::TIME_W-1:0]   ct_next;
  logic [srtf_pkg::CNT_W-1:0]    cc_next;
  logic [srtf_pkg::TIME_W-1:0]   tat_next;
  logic [srtf_pkg::TIME_W-1:0]   wait_val;

  // An active count above the table depth is clamped to the depth.
  assign active = (AW'(process_count) > AW'(MAX_PROCESSES)) ?
                  AW'(MAX_PROCESSES) : AW'(process_count);
  assign done_now = AW'(completed_count) >= active;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign slot_x   = {{IDX_W{1'b0}}, slot};

  // The search starts from an empty candidate at the head of the chain.
  assign cand[0] = '0;
  assign idx[0]  = '0;

  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    // A load to a slot beyond the table matches no cell and is dropped.
    assign ctrl[i].wr  = accept && (action == srtf_pkg::ACT_LOAD)
                       && (slot_x == (IDX_W+srtf_pkg::SLOT_W)'(i));
    assign ctrl[i].dec = (state == S_UPDATE) && last.found && (last_idx == IDX_W'(i));
    assign ctrl[i].en  = AW'(i) < active;

    srtf_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl[i]),
      .wr_arrival   (arrival_time),
      .wr_burst     (burst_time),
      .current_time (current_time),
      .cand_in      (cand[i]),
      .idx_in       (idx[i]),
      .cand_out     (cand[i+1]),
      .idx_out      (idx[i+1])
    );
  end

  assign last     = cand[MAX_PROCESSES];
  assign last_idx = idx[MAX_PROCESSES];
  assign win_x    = {{srtf_pkg::SLOT_W{1'b0}}, last_idx};

  always_comb begin
    fin_hit  = last.found && (last.rt == srtf_pkg::VAL_W'(1));
    ct_next  = (current_time < srtf_pkg::TIME_MAX) ? current_time + 1'b1 : current_time;
    cc_next  = completed_count;
    if (fin_hit && (completed_count < srtf_pkg::COUNT_MAX)) begin
      cc_next = completed_count + 1'b1;
    end
    tat_next = ct_next - {{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, last.arrival};
    // Waiting time is floored at zero.
    if (p_tat > {{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, p_burst}) begin
      wait_val = p_tat - {{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, p_burst};
    end else begin
      wait_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= '0;
    end else if (cfg_write) begin
      process_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      scan_cnt        <= '0;
      current_time    <= '0;
      completed_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      // The result stage reloads the output register itself when it is taken.
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            p_ran   <= '0;
            p_idle  <= 1'b1;
            p_fin   <= 1'b0;
            p_ct    <= '0;
            p_tat   <= '0;
            p_burst <= '0;
            p_done  <= done_now;
            if ((action == srtf_pkg::ACT_TICK) && !done_now) begin
              scan_cnt <= '0;
              state    <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          // The slot state is frozen here, so once the search has passed every cell the
          // tail of the chain holds the winner.
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == IDX_W'(MAX_PROCESSES - 1)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          current_time    <= ct_next;
          completed_count <= cc_next;
          p_done          <= AW'(cc_next) >= active;
          if (last.found) begin
            p_ran  <= win_x[srtf_pkg::SLOT_W-1:0];
            p_idle <= 1'b0;
          end
          if (fin_hit) begin
            p_fin   <= 1'b1;
            p_ct    <= ct_next;
            p_tat   <= tat_next;
            p_burst <= last.burst;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            ran_slot        <= p_ran;
            cpu_idle        <= p_idle;
            finished        <= p_fin;
            completion_time <= p_ct;
            turnaround      <= p_tat;
            waiting         <= wait_val;
            all_done        <= p_done;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/srtf_checker.sv @@
// ---------------------------------------------------------------------------
// SRTF scheduler checker
// Port-level assertions on the scheduler's result stream.
// ---------------------------------------------------------------------------
`include "srtf_scheduler_defines.svh"

module srtf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [srtf_pkg::SLOT_W-1:0]        ran_slot,
  input logic                               cpu_idle,
  input logic                               finished,
  input logic [srtf_pkg::TIME_W-1:0]        completion_time,
  input logic [srtf_pkg::TIME_W-1:0]        turnaround,
  input logic [srtf_pkg::TIME_W-1:0]        waiting
);

  // An accepted item keeps the input side busy in the following cycle.
  `SRTF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A stalled result stays in place.
  `SRTF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ran_slot) && $stable(cpu_idle) && $stable(finished) && $stable(completion_time) && $stable(waiting))

  // A completion always comes from a served slot.
  `SRTF_ASSERT_NOW(a_fin_served, out_valid && finished, !cpu_idle)

  // Without a completion the timing fields are zero.
  `SRTF_ASSERT_NOW(a_no_fin_zero, out_valid && !finished, completion_time == '0 && turnaround == '0 && waiting == '0)

  // Waiting never exceeds turnaround, which never exceeds completion time.
  `SRTF_ASSERT_NOW(a_time_order, out_valid && finished, waiting <= turnaround && turnaround <= completion_time)

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (.*);
